// ===== hdl/iphc_pkg.sv =====
package iphc_pkg;

	localparam logic [2:0]  DISPATCH     = 3'b011;
	localparam logic [3:0]  IPV6_VERSION = 4'd6;
	localparam logic [7:0]  MCAST_MARK   = 8'hff;
	localparam logic [7:0]  ALL_NODES    = 8'h02;
	localparam logic [63:0] LL_PREFIX    = 64'hfe80_0000_0000_0000;
	localparam logic [47:0] MAPPED_IID   = 48'h0000_00ff_fe00;

	localparam logic [1:0] TF_FULL     = 2'b00;
	localparam logic [1:0] TF_NO_DSCP  = 2'b01;
	localparam logic [1:0] TF_NO_FLOW  = 2'b10;

	localparam logic [1:0] HLIM_INLINE = 2'b00;
	localparam logic [1:0] HLIM_1      = 2'b01;
	localparam logic [1:0] HLIM_64     = 2'b10;
	localparam logic [1:0] HLIM_255    = 2'b11;

	localparam logic [7:0] HOP_1       = 8'd1;
	localparam logic [7:0] HOP_64      = 8'd64;
	localparam logic [7:0] HOP_255     = 8'd255;

	localparam logic [1:0] AM_FULL     = 2'b00;
	localparam logic [1:0] AM_64       = 2'b01;
	localparam logic [1:0] AM_16       = 2'b10;
	localparam logic [1:0] AM_ELIDED   = 2'b11;

	typedef struct packed {
		logic [7:0]         b0;
		logic [7:0]         b1;
		logic [0:3][7:0]    tf_bytes;
		logic [2:0]         tf_cnt;
		logic [7:0]         nh;
		logic [7:0]         hl;
		logic               hl_inl;
		logic [0:15][7:0]   src_bytes;
		logic [4:0]         src_cnt;
		logic [0:15][7:0]   dst_bytes;
		logic [4:0]         dst_cnt;
		logic               verr;
	} desc_t;

endpackage

// ===== hdl/iphc_in_if.sv =====
interface iphc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] ver_class_flow;
	logic [7:0]  next_header;
	logic [7:0]  hop_limit;
	logic [63:0] src_high;
	logic [63:0] src_low;
	logic [63:0] dst_high;
	logic [63:0] dst_low;
	logic [63:0] src_ident;
	logic [63:0] dst_ident;

	modport source (
		output valid, ver_class_flow, next_header, hop_limit,
		output src_high, src_low, dst_high, dst_low, src_ident, dst_ident,
		input  ready
	);
	modport sink (
		input  valid, ver_class_flow, next_header, hop_limit,
		input  src_high, src_low, dst_high, dst_low, src_ident, dst_ident,
		output ready
	);
endinterface

// ===== hdl/iphc_out_if.sv =====
interface iphc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;
	logic       version_error;

	modport source (output valid, out_byte, last_byte, version_error, input ready);
	modport sink (input valid, out_byte, last_byte, version_error, output ready);
endinterface

// ===== hdl/iphc_front.sv =====
module iphc_front (
	input  logic          clk,
	input  logic          arst_n,
	iphc_in_if.sink       hdr,
	output iphc_pkg::desc_t desc,
	output logic          desc_valid,
	input  logic          desc_ready
);
	import iphc_pkg::*;

	typedef struct packed {
		logic [1:0]       mode;
		logic [0:15][7:0] bytes;
		logic [4:0]       cnt;
	} addr_enc_t;

	function automatic addr_enc_t enc_unicast(logic [63:0] hi, logic [63:0] lo,
		logic [63:0] ident);
		addr_enc_t e;
		if (hi != LL_PREFIX) begin
			e.mode  = AM_FULL;
			e.bytes = {hi, lo};
			e.cnt   = 5'd16;
		end else if (lo == ident) begin
			e.mode  = AM_ELIDED;
			e.bytes = '0;
			e.cnt   = 5'd0;
		end else if (lo[63:16] == MAPPED_IID) begin
			e.mode  = AM_16;
			e.bytes = {lo[15:0], 112'h0};
			e.cnt   = 5'd2;
		end else begin
			e.mode  = AM_64;
			e.bytes = {lo, 64'h0};
			e.cnt   = 5'd8;
		end
		return e;
	endfunction

	function automatic addr_enc_t enc_multicast(logic [63:0] hi, logic [63:0] lo);
		addr_enc_t e;
		if (hi[55:48] == ALL_NODES && hi[47:0] == '0 && lo[63:8] == '0) begin
			e.mode  = AM_ELIDED;
			e.bytes = {lo[7:0], 120'h0};
			e.cnt   = 5'd1;
		end else if (hi[47:0] == '0 && lo[63:24] == '0) begin
			e.mode  = AM_16;
			e.bytes = {hi[55:48], lo[23:0], 96'h0};
			e.cnt   = 5'd4;
		end else if (hi[47:0] == '0 && lo[63:40] == '0) begin
			e.mode  = AM_64;
			e.bytes = {hi[55:48], lo[39:0], 80'h0};
			e.cnt   = 5'd6;
		end else begin
			e.mode  = AM_FULL;
			e.bytes = {hi, lo};
			e.cnt   = 5'd16;
		end
		return e;
	endfunction

	desc_t      desc_c;
	desc_t      desc_s1;
	logic       valid_s1;
	logic       take;
	logic [7:0] tclass;
	logic [5:0] dscp;
	logic [1:0] ecn;
	logic [19:0] flow;
	logic [1:0] tf;
	logic [1:0] hlim;
	logic       mcast;
	addr_enc_t  src_e;
	addr_enc_t  dst_e;

	assign tclass = hdr.ver_class_flow[27:20];
	assign dscp   = tclass[7:2];
	assign ecn    = tclass[1:0];
	assign flow   = hdr.ver_class_flow[19:0];
	assign mcast  = hdr.dst_high[63:56] == MCAST_MARK;
	assign src_e  = enc_unicast(hdr.src_high, hdr.src_low, hdr.src_ident);
	assign dst_e  = mcast ? enc_multicast(hdr.dst_high, hdr.dst_low)
		: enc_unicast(hdr.dst_high, hdr.dst_low, hdr.dst_ident);

	always_comb begin
		desc_c = '0;
		priority if (flow == '0) begin
			tf              = TF_NO_FLOW;
			desc_c.tf_bytes = {ecn, dscp, 24'h0};
			desc_c.tf_cnt   = 3'd1;
		end else if (dscp == '0) begin
			tf              = TF_NO_DSCP;
			desc_c.tf_bytes = {ecn, 2'b00, flow, 8'h00};
			desc_c.tf_cnt   = 3'd3;
		end else begin
			tf              = TF_FULL;
			desc_c.tf_bytes = {ecn, dscp, 4'h0, flow};
			desc_c.tf_cnt   = 3'd4;
		end
		priority if (hdr.hop_limit == HOP_255) hlim = HLIM_255;
		else if (hdr.hop_limit == HOP_64) hlim = HLIM_64;
		else if (hdr.hop_limit == HOP_1) hlim = HLIM_1;
		else hlim = HLIM_INLINE;
		desc_c.b0        = {DISPATCH, tf, 1'b0, hlim};
		desc_c.b1        = {2'b00, src_e.mode, mcast, 1'b0, dst_e.mode};
		desc_c.nh        = hdr.next_header;
		desc_c.hl        = hdr.hop_limit;
		desc_c.hl_inl    = hlim == HLIM_INLINE;
		desc_c.src_bytes = src_e.bytes;
		desc_c.src_cnt   = src_e.cnt;
		desc_c.dst_bytes = dst_e.bytes;
		desc_c.dst_cnt   = dst_e.cnt;
		desc_c.verr      = hdr.ver_class_flow[31:28] != IPV6_VERSION;
	end

	assign hdr.ready  = !valid_s1 || desc_ready;
	assign take       = hdr.valid && hdr.ready;
	assign desc       = desc_s1;
	assign desc_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			valid_s1 <= hdr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			desc_s1 <= desc_c;
		end
	end
endmodule

// ===== hdl/iphc_queue.sv =====
module iphc_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  iphc_pkg::desc_t push_data,
	input  logic            push_valid,
	output logic            push_ready,
	output iphc_pkg::desc_t head,
	output logic            head_valid,
	input  logic            pop
);
	import iphc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t         slots_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slots_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

// ===== hdl/iphc_back.sv =====
module iphc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  iphc_pkg::desc_t head,
	input  logic            head_valid,
	output logic            pop,
	iphc_out_if.source      cmp
);
	import iphc_pkg::*;

	typedef enum logic [2:0] {
		SEG_BASE,
		SEG_TF,
		SEG_NH,
		SEG_HL,
		SEG_SRC,
		SEG_DST
	} seg_t;

	seg_t       seg_q;
	seg_t       seg_nxt;
	logic [3:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       verr_q;
	logic       adv;
	logic       fire;
	logic [7:0] byte_c;
	logic       seg_end;
	logic       last_c;
	logic       src_none;
	logic       dst_none;
	seg_t       after_hl;

	assign adv      = !valid_q || cmp.ready;
	assign fire     = adv && head_valid;
	assign src_none = head.src_cnt == '0;
	assign dst_none = head.dst_cnt == '0;
	// both addresses elided: the header ends on the next header or hop limit byte
	assign after_hl = !src_none ? SEG_SRC : (!dst_none ? SEG_DST : SEG_BASE);

	always_comb begin
		byte_c  = '0;
		seg_end = 1'b0;
		seg_nxt = seg_q;
		unique case (seg_q)
			SEG_BASE: begin
				byte_c  = idx_q[0] ? head.b1 : head.b0;
				seg_end = idx_q[0];
				seg_nxt = SEG_TF;
			end
			SEG_TF: begin
				byte_c  = head.tf_bytes[idx_q[1:0]];
				seg_end = {1'b0, idx_q[1:0]} == head.tf_cnt - 3'd1;
				seg_nxt = SEG_NH;
			end
			SEG_NH: begin
				byte_c  = head.nh;
				seg_end = 1'b1;
				seg_nxt = head.hl_inl ? SEG_HL : after_hl;
			end
			SEG_HL: begin
				byte_c  = head.hl;
				seg_end = 1'b1;
				seg_nxt = after_hl;
			end
			SEG_SRC: begin
				byte_c  = head.src_bytes[idx_q];
				seg_end = {1'b0, idx_q} == head.src_cnt - 5'd1;
				seg_nxt = dst_none ? SEG_BASE : SEG_DST;
			end
			SEG_DST: begin
				byte_c  = head.dst_bytes[idx_q];
				seg_end = {1'b0, idx_q} == head.dst_cnt - 5'd1;
				seg_nxt = SEG_BASE;
			end
			default: begin
				seg_nxt = SEG_BASE;
			end
		endcase
		last_c = seg_end && seg_nxt == SEG_BASE;
	end

	assign pop = fire && last_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q   <= SEG_BASE;
			idx_q   <= '0;
			valid_q <= 1'b0;
			byte_q  <= '0;
			last_q  <= 1'b0;
			verr_q  <= 1'b0;
		end else if (adv) begin
			valid_q <= head_valid;
			if (head_valid) begin
				byte_q <= byte_c;
				last_q <= last_c;
				verr_q <= head.verr;
				if (seg_end) begin
					seg_q <= seg_nxt;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end
		end
	end

	assign cmp.valid         = valid_q;
	assign cmp.out_byte      = byte_q;
	assign cmp.last_byte     = last_q;
	assign cmp.version_error = verr_q;
endmodule

// ===== hdl/iphc_header_compress.sv =====
// stateless 6lowpan iphc header compressor
// hdr channel: one ipv6 header per beat (version/class/flow, next header,
//   hop limit, source and destination addresses, both interface identifiers)
// cmp channel: the compressed header, one byte per beat in transmit order,
//   last_byte high on its final byte, version_error high on every byte of a
//   header whose version field is not 6
// a header yields 4 to 40 bytes, which the byte sequencer emits one byte per
//   cycle while the receiver keeps ready high; this sequencer sets the throughput
// a header passes the classification register, a queue slot and then the byte
//   output register before its first byte is presented
// the front stage registers each classified header and hands it to a queue
//   of QUEUE_DEPTH entries, so further headers are taken while bytes drain
// when the receiver holds ready low the current byte stays on cmp, the
//   sequencer waits, and hdr.ready falls once the queue and front stage fill
// reset empties the queue and the output register; no clearing pass is needed
module iphc_header_compress #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	iphc_in_if.sink     hdr,
	iphc_out_if.source  cmp
);
	import iphc_pkg::*;

	desc_t front_desc;
	logic  front_valid;
	logic  queue_ready;
	desc_t head;
	logic  head_valid;
	logic  pop;

	iphc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hdr        (hdr),
		.desc       (front_desc),
		.desc_valid (front_valid),
		.desc_ready (queue_ready)
	);

	iphc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (front_desc),
		.push_valid (front_valid),
		.push_ready (queue_ready),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	iphc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.cmp        (cmp)
	);
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import iphc_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_HEADERS = 230;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [63:0] IID_A = 64'h0211_22ff_fe33_4455;
	localparam logic [63:0] IID_B = 64'h0266_77ff_fe88_99aa;

	typedef struct packed {
		logic [31:0] vcf;
		logic [7:0]  nh;
		logic [7:0]  hl;
		logic [63:0] src_hi, src_lo, dst_hi, dst_lo, src_iid, dst_iid;
	} ipv6_hdr_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
		logic       version_error;
	} cmp_beat_t;

	// n > 0: the first n bytes of b are the known compressed form
	typedef struct {
		ipv6_hdr_t   h;
		int          n;
		logic [39:0] b;
		logic        verr;
	} hdr_row_t;

	logic clk;
	logic arst_n;
	int gap_pct;
	int stall_pct;
	int cycle_count;
	int mismatches;
	logic [7:0] iphc_bytes[$];
	cmp_beat_t pending_bytes[$];
	cmp_beat_t want;

	iphc_in_if hdr_if ();
	iphc_out_if cmp_if ();

	iphc_header_compress DUT (
		.clk(clk),
		.arst_n(arst_n),
		.hdr(hdr_if),
		.cmp(cmp_if)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic ipv6_hdr_t mk_hdr(input logic [31:0] vcf, input logic [7:0] nh, hl,
			input logic [63:0] src_hi, src_lo, dst_hi, dst_lo, src_iid, dst_iid);
		return {vcf, nh, hl, src_hi, src_lo, dst_hi, dst_lo, src_iid, dst_iid};
	endfunction

	function automatic hdr_row_t row(input ipv6_hdr_t h, input int n, input logic [39:0] b,
			input logic verr);
		hdr_row_t r;
		r.h = h;
		r.n = n;
		r.b = b;
		r.verr = verr;
		return r;
	endfunction

	function automatic void put_range(input logic [127:0] a, input int lo_i, hi_i);
		int i;
		for (i = lo_i; i <= hi_i; i++)
			iphc_bytes.push_back(a[127 - 8 * i -: 8]);
	endfunction

	function automatic logic [1:0] put_unicast(input logic [63:0] hi, lo, iid);
		if (hi != LL_PREFIX) begin
			put_range({hi, lo}, 0, 15);
			return AM_FULL;
		end
		if (lo == iid)
			return AM_ELIDED;
		if (lo[63:16] == MAPPED_IID) begin
			put_range({hi, lo}, 14, 15);
			return AM_16;
		end
		put_range({hi, lo}, 8, 15);
		return AM_64;
	endfunction

	function automatic logic [1:0] put_multicast(input logic [127:0] a);
		if (a[119:112] == ALL_NODES && a[111:8] == '0) begin
			put_range(a, 15, 15);
			return AM_ELIDED;
		end
		if (a[111:24] == '0) begin
			put_range(a, 1, 1);
			put_range(a, 13, 15);
			return AM_16;
		end
		if (a[111:40] == '0) begin
			put_range(a, 1, 1);
			put_range(a, 11, 15);
			return AM_64;
		end
		put_range(a, 0, 15);
		return AM_FULL;
	endfunction

	function automatic void compress_header(input ipv6_hdr_t h);
		logic [7:0] tclass;
		logic [19:0] flow;
		logic [1:0] tf, hlim, sam, dam;
		logic m;
		logic [31:0] w;
		cmp_beat_t beat;
		int k;
		tclass = h.vcf[27:20];
		flow = h.vcf[19:0];
		iphc_bytes = {};
		iphc_bytes.push_back(8'h00);
		iphc_bytes.push_back(8'h00);
		if (flow == '0) begin
			tf = TF_NO_FLOW;
			iphc_bytes.push_back({tclass[1:0], tclass[7:2]});
		end else if (tclass[7:2] == '0) begin
			tf = TF_NO_DSCP;
			w = {8'h00, tclass[1:0], 2'b00, flow};
			put_range({w, 96'h0}, 1, 3);
		end else begin
			tf = TF_FULL;
			w = {tclass[1:0], tclass[7:2], 4'h0, flow};
			put_range({w, 96'h0}, 0, 3);
		end
		iphc_bytes.push_back(h.nh);
		case (h.hl)
			HOP_255: hlim = HLIM_255;
			HOP_64: hlim = HLIM_64;
			HOP_1: hlim = HLIM_1;
			default: begin
				hlim = HLIM_INLINE;
				iphc_bytes.push_back(h.hl);
			end
		endcase
		sam = put_unicast(h.src_hi, h.src_lo, h.src_iid);
		m = (h.dst_hi[63:56] == MCAST_MARK);
		if (m)
			dam = put_multicast({h.dst_hi, h.dst_lo});
		else
			dam = put_unicast(h.dst_hi, h.dst_lo, h.dst_iid);
		iphc_bytes[0] = {DISPATCH, tf, 1'b0, hlim};
		iphc_bytes[1] = {2'b00, sam, m, 1'b0, dam};
		for (k = 0; k < iphc_bytes.size(); k++) begin
			beat.out_byte = iphc_bytes[k];
			beat.last_byte = (k == iphc_bytes.size() - 1);
			beat.version_error = (h.vcf[31:28] != IPV6_VERSION);
			pending_bytes.push_back(beat);
		end
	endfunction

	function automatic logic [127:0] random_unicast(input logic [63:0] iid);
		logic [127:0] a;
		a = {rand64(), rand64()};
		case ($urandom_range(0, 4))
			0: ;
			1: a = {LL_PREFIX, iid};
			2: a = {LL_PREFIX, MAPPED_IID, a[15:0]};
			3: a[127:64] = LL_PREFIX;
			default: a[127:64] = LL_PREFIX ^ (64'h1 << $urandom_range(0, 63));
		endcase
		return a;
	endfunction

	function automatic logic [127:0] random_multicast();
		logic [127:0] a;
		a = {rand64(), rand64()};
		a[127:120] = MCAST_MARK;
		case ($urandom_range(0, 4))
			0: begin
				a[119:112] = ALL_NODES;
				a[111:8] = '0;
			end
			1: a[111:24] = '0;
			2: a[111:40] = '0;
			3: a[111:8] = '0;
			default: ;
		endcase
		return a;
	endfunction

	function automatic ipv6_hdr_t random_hdr();
		ipv6_hdr_t h;
		h.vcf = $urandom;
		if ($urandom_range(0, 9) != 0)
			h.vcf[31:28] = IPV6_VERSION;
		case ($urandom_range(0, 3))
			0: h.vcf[19:0] = '0;
			1: h.vcf[27:22] = '0;
			default: ;
		endcase
		h.nh = 8'($urandom);
		case ($urandom_range(0, 4))
			0: h.hl = HOP_1;
			1: h.hl = HOP_64;
			2: h.hl = HOP_255;
			default: h.hl = 8'($urandom);
		endcase
		h.src_iid = rand64();
		h.dst_iid = rand64();
		{h.src_hi, h.src_lo} = random_unicast(h.src_iid);
		if ($urandom_range(0, 9) < 4)
			{h.dst_hi, h.dst_lo} = random_multicast();
		else
			{h.dst_hi, h.dst_lo} = random_unicast(h.dst_iid);
		return h;
	endfunction

	task automatic send_header(input ipv6_hdr_t h);
		hdr_if.valid <= 1'b1;
		hdr_if.ver_class_flow <= h.vcf;
		hdr_if.next_header <= h.nh;
		hdr_if.hop_limit <= h.hl;
		hdr_if.src_high <= h.src_hi;
		hdr_if.src_low <= h.src_lo;
		hdr_if.dst_high <= h.dst_hi;
		hdr_if.dst_low <= h.dst_lo;
		hdr_if.src_ident <= h.src_iid;
		hdr_if.dst_ident <= h.dst_iid;
		do @(posedge clk); while (!hdr_if.ready);
	endtask

	task automatic sender_pause();
		if ($urandom_range(0, 99) < gap_pct) begin
			hdr_if.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// receiver stalls
	initial begin
		cmp_if.ready = 1'b1;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < stall_pct) begin
				cmp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				cmp_if.ready <= 1'b1;
			end
		end
	end

	// byte checker and watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else if (arst_n && cmp_if.valid && cmp_if.ready) begin
			if (pending_bytes.size() == 0) begin
				$error("out_byte: expected none, actual %h", cmp_if.out_byte);
				mismatches++;
			end else begin
				want = pending_bytes.pop_front();
				if (cmp_if.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, actual %h", want.out_byte, cmp_if.out_byte);
					mismatches++;
				end
				if (cmp_if.last_byte !== want.last_byte) begin
					$error("last_byte: expected %b, actual %b", want.last_byte,
						cmp_if.last_byte);
					mismatches++;
				end
				if (cmp_if.version_error !== want.version_error) begin
					$error("version_error: expected %b, actual %b", want.version_error,
						cmp_if.version_error);
					mismatches++;
				end
			end
		end
	end

	initial begin
		hdr_row_t rows[$];
		hdr_row_t r;
		ipv6_hdr_t h;
		cmp_beat_t beat;
		int i;
		int k;

		cycle_count = 0;
		mismatches = 0;
		gap_pct = 20;
		stall_pct = 20;
		arst_n = 1'b0;
		hdr_if.valid = 1'b0;
		hdr_if.ver_class_flow = '0;
		hdr_if.next_header = '0;
		hdr_if.hop_limit = '0;
		hdr_if.src_high = '0;
		hdr_if.src_low = '0;
		hdr_if.dst_high = '0;
		hdr_if.dst_low = '0;
		hdr_if.src_ident = '0;
		hdr_if.dst_ident = '0;

		// fully elided forms, known bytes
		rows.push_back(row(mk_hdr(32'h6000_0000, 8'h11, HOP_64, LL_PREFIX, IID_A,
			LL_PREFIX, IID_B, IID_A, IID_B), 4, 40'h72_33_00_11_00, 1'b0));
		rows.push_back(row(mk_hdr(32'h0000_0000, 8'h00, HOP_255, LL_PREFIX, IID_A,
			LL_PREFIX, IID_B, IID_A, IID_B), 4, 40'h73_33_00_00_00, 1'b1));
		rows.push_back(row(mk_hdr(32'h6000_0000, 8'h3a, HOP_1, LL_PREFIX, IID_A,
			64'hff02_0000_0000_0000, 64'h1, IID_A, IID_B), 5, 40'h71_3b_00_3a_01, 1'b0));
		rows.push_back(row(mk_hdr(32'h6ff0_0000, 8'hff, HOP_64, LL_PREFIX, IID_A,
			LL_PREFIX, IID_B, IID_A, IID_B), 4, 40'h72_33_ff_ff_00, 1'b0));
		// extremes
		rows.push_back(row(mk_hdr('1, '1, '1, '1, '1, '1, '1, '1, '1), 0, '0, 1'b0));
		rows.push_back(row(mk_hdr('0, '0, '0, '0, '0, '0, '0, '0, '0), 0, '0, 1'b0));
		rows.push_back(row(mk_hdr(32'h6fff_ffff, 8'h06, 8'hfe, 64'h2001_0db8_0000_0001,
			64'hfedc_ba98_7654_3210, 64'hff0e_0000_0000_0001, 64'h0123_4567_89ab_cdef,
			IID_A, IID_B), 0, '0, 1'b0));
		// traffic class / flow forms and link-local iid forms
		rows.push_back(row(mk_hdr(32'h6030_0001, 8'h11, 8'h02, LL_PREFIX,
			64'h1234_5678_9abc_def0, LL_PREFIX, 64'h0000_00ff_fe00_beef, IID_A, IID_B),
			0, '0, 1'b0));
		rows.push_back(row(mk_hdr(32'h6041_2345, 8'h3a, 8'd63, LL_PREFIX,
			64'h0000_00ff_fe00_0001, LL_PREFIX, 64'h0000_00ff_fe01_0002, IID_A, IID_B),
			0, '0, 1'b0));
		rows.push_back(row(mk_hdr(32'h600f_ffff, 8'h2c, 8'd65, LL_PREFIX,
			64'h0000_00ff_fe00_0001, LL_PREFIX, IID_B, 64'h0000_00ff_fe00_0001, IID_B),
			0, '0, 1'b0));
		rows.push_back(row(mk_hdr(32'h6abc_de00, 8'h01, 8'd254, 64'hfe80_0000_0000_0001,
			IID_A, 64'h7e80_0000_0000_0000, IID_B, IID_A, IID_B), 0, '0, 1'b0));
		// multicast forms
		rows.push_back(row(mk_hdr(32'h6000_0000, 8'h11, HOP_255, LL_PREFIX, IID_A,
			64'hff05_0000_0000_0000, 64'h0000_0000_00ab_cdef, IID_A, IID_B), 0, '0, 1'b0));
		rows.push_back(row(mk_hdr(32'h6000_0000, 8'h11, HOP_255, LL_PREFIX, IID_A,
			64'hff02_0000_0000_0000, 64'h0000_0012_3456_789a, IID_A, IID_B), 0, '0, 1'b0));
		rows.push_back(row(mk_hdr(32'h6000_0000, 8'h3a, HOP_255, LL_PREFIX, IID_A,
			64'hff02_0000_0000_0000, 64'h0000_0001_ff00_0001, IID_A, IID_B), 0, '0, 1'b0));
		rows.push_back(row(mk_hdr(32'h6000_0000, 8'h3a, HOP_1, LL_PREFIX, IID_A,
			64'hff05_0000_0000_0000, 64'h1, IID_A, IID_B), 0, '0, 1'b0));
		rows.push_back(row(mk_hdr(32'h6000_0000, 8'h3a, HOP_1, LL_PREFIX, IID_A,
			64'hff02_0100_0000_0000, 64'h1, IID_A, IID_B), 0, '0, 1'b0));
		rows.push_back(row(mk_hdr(32'h6000_0000, 8'h3a, HOP_64, LL_PREFIX, IID_A,
			64'hff02_0000_0000_0000, 64'h0, IID_A, IID_B), 0, '0, 1'b0));
		rows.push_back(row(mk_hdr(32'h6000_0000, 8'h3a, HOP_64, LL_PREFIX, IID_A,
			64'hff00_0000_0000_0000, 64'h1, IID_A, IID_B), 0, '0, 1'b0));
		// bad version, every field inline but the all-nodes multicast destination (one byte)
		rows.push_back(row(mk_hdr(32'h7abc_def0, 8'h80, 8'h80, 64'h2001_0db8_aaaa_bbbb,
			64'hcccc_dddd_eeee_ffff, 64'hff02_0000_0000_0000, 64'h2, IID_A, IID_B),
			0, '0, 1'b0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			r = rows[i];
			send_header(r.h);
			if (r.n > 0) begin
				for (k = 0; k < r.n; k++) begin
					beat.out_byte = r.b[39 - 8 * k -: 8];
					beat.last_byte = (k == r.n - 1);
					beat.version_error = r.verr;
					pending_bytes.push_back(beat);
				end
			end else begin
				compress_header(r.h);
			end
			sender_pause();
		end

		gap_pct = 25;
		stall_pct = 20;
		for (i = 0; i < RANDOM_HEADERS; i++) begin
			if (i == 60) begin
				gap_pct = 0;
				stall_pct = 0;
			end else if (i == 100) begin
				gap_pct = 40;
				stall_pct = 35;
			end else if (i == 190) begin
				gap_pct = 0;
				stall_pct = 0;
			end
			if (i == 140) begin
				// hold off until every pending byte is out
				hdr_if.valid <= 1'b0;
				@(posedge clk);
				while (pending_bytes.size() != 0) @(posedge clk);
			end
			h = random_hdr();
			send_header(h);
			compress_header(h);
			sender_pause();
		end

		hdr_if.valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/iphc_pkg.sv
hdl/iphc_in_if.sv
hdl/iphc_out_if.sv
hdl/iphc_front.sv
hdl/iphc_queue.sv
hdl/iphc_back.sv
hdl/iphc_header_compress.sv
sim/tb.sv
